[rtl/yuvq_pkg.sv]
// Shared types, register codes and constant tables for the YCbCr 4:2:0 quad
// to BGRA converter. No dependencies; every other file in rtl imports it.
`default_nettype none

package yuvq_pkg;

	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 8;
	localparam int LANES       = 4;
	localparam int CHANNELS    = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_LIMITED_RANGE = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_ENABLE  = CFG_INDEX_W'(1);

	// Channel order inside a lane follows the packing, blue lowest.
	localparam int CH_BLUE  = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_RED   = 2;

	// Widest dividend magnitude in the tables fits below 2**DIV_BITS.
	localparam int DIV_BITS = 18;

	typedef struct packed {
		logic limited_range;
		logic alpha_enable;
	} cfg_t;

	typedef logic signed [8:0] chroma_off_t;
	typedef logic [LANES-1:0][7:0] lane_byte_t;
	typedef logic [LANES-1:0][CHANNELS-1:0][7:0] lane_code_t;
	typedef logic [LANES-1:0][31:0] lane_pixel_t;

	typedef logic [255:0][8:0] off_rom_t;
	typedef logic [255:0][7:0] lim_rom_t;

	// Quotient truncated toward zero by restoring long division, for a
	// positive divisor. Only evaluated while the tables are built.
	function automatic int div_trunc(input int num, input int den);
		int   mag;
		int   q;
		int   r;
		logic neg;
		neg = (num < 0);
		mag = neg ? -num : num;
		q   = 0;
		r   = 0;
		for (int b = DIV_BITS - 1; b >= 0; b--) begin
			r = (r << 1) | ((mag >> b) & 1);
			if (r >= den) begin
				r = r - den;
				q = q | (1 << b);
			end
		end
		return neg ? -q : q;
	endfunction

	// Offset tables are indexed by the raw chroma byte; entries truncate
	// toward zero, matching integer division of the scaled offset.
	function automatic off_rom_t build_off_rom(input int num, input int den);
		off_rom_t rom;
		int       c;
		for (int i = 0; i < 256; i++) begin
			c = i - 128;
			rom[i] = 9'(div_trunc(num * c, den));
		end
		return rom;
	endfunction

	function automatic lim_rom_t build_lim_rom();
		lim_rom_t rom;
		for (int i = 0; i < 256; i++) begin
			rom[i] = (i <= 219) ? 8'(div_trunc(i * 255, 219)) : 8'hFF;
		end
		return rom;
	endfunction

	localparam off_rom_t DR_ROM    = build_off_rom(419, 299);
	localparam off_rom_t DG_CR_ROM = build_off_rom(-299, 419);
	localparam off_rom_t DG_CB_ROM = build_off_rom(-114, 331);
	localparam off_rom_t DB_ROM    = build_off_rom(587, 331);
	localparam lim_rom_t LIM_ROM   = build_lim_rom();

endpackage

`default_nettype wire

[rtl/yuvq_offset.sv]
// First pipeline stage: chroma offset table lookups and input capture.
// Depends on yuvq_pkg for the offset tables and lane types.
`default_nettype none

module yuvq_offset import yuvq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        advance,
	input  wire logic [7:0]  chroma_blue,
	input  wire logic [7:0]  chroma_red,
	input  wire lane_byte_t  luma,
	input  wire lane_byte_t  alpha,
	output logic             valid_s1,
	output chroma_off_t      dr_s1,
	output chroma_off_t      dg_s1,
	output chroma_off_t      db_s1,
	output lane_byte_t       luma_s1,
	output lane_byte_t       alpha_s1
);

	chroma_off_t dg_cr;
	chroma_off_t dg_cb;

	assign dg_cr = chroma_off_t'(DG_CR_ROM[chroma_red]);
	assign dg_cb = chroma_off_t'(DG_CB_ROM[chroma_blue]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			dr_s1    <= chroma_off_t'(DR_ROM[chroma_red]);
			dg_s1    <= dg_cr + dg_cb;
			db_s1    <= chroma_off_t'(DB_ROM[chroma_blue]);
			luma_s1  <= luma;
			alpha_s1 <= alpha;
		end
	end

endmodule

`default_nettype wire

[rtl/yuvq_range.sv]
// Second pipeline stage: adds offsets to luma and clamps each channel.
// In studio range it emits the clamped value less 16, ready for scaling.
// Depends on yuvq_pkg for the configuration struct and lane types.
`default_nettype none

module yuvq_range import yuvq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        valid_s1,
	input  wire logic        advance,
	input  wire chroma_off_t dr_s1,
	input  wire chroma_off_t dg_s1,
	input  wire chroma_off_t db_s1,
	input  wire lane_byte_t  luma_s1,
	input  wire lane_byte_t  alpha_s1,
	output logic             valid_s2,
	output lane_code_t       code_s2,
	output lane_byte_t       alpha_s2
);

	function automatic logic [7:0] chan_code(input logic [7:0] y, input chroma_off_t d,
			input logic limited);
		logic signed [9:0] v;
		logic [7:0]        code;
		v = $signed({2'b00, y}) + $signed({d[8], d});
		if (limited) begin
			if (v < 10'sd16) begin
				code = 8'd0;
			end else if (v > 10'sd235) begin
				code = 8'd219;
			end else begin
				code = 8'(v - 10'sd16);
			end
		end else begin
			if (v < 10'sd0) begin
				code = 8'd0;
			end else if (v > 10'sd255) begin
				code = 8'd255;
			end else begin
				code = v[7:0];
			end
		end
		return code;
	endfunction

	lane_code_t code;

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			code[k][CH_BLUE]  = chan_code(luma_s1[k], db_s1, cfg.limited_range);
			code[k][CH_GREEN] = chan_code(luma_s1[k], dg_s1, cfg.limited_range);
			code[k][CH_RED]   = chan_code(luma_s1[k], dr_s1, cfg.limited_range);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			code_s2  <= code;
			alpha_s2 <= alpha_s1;
		end
	end

endmodule

`default_nettype wire

[rtl/yuvq_pack.sv]
// Third pipeline stage: studio range expansion, alpha select and BGRA packing.
// Holds the output register. Depends on yuvq_pkg for the expansion table.
`default_nettype none

module yuvq_pack import yuvq_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire logic       valid_s2,
	input  wire logic       advance,
	input  wire lane_code_t code_s2,
	input  wire lane_byte_t alpha_s2,
	output logic            valid_s3,
	output lane_pixel_t     pixel_s3
);

	lane_pixel_t pixel;

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			for (int c = 0; c < CHANNELS; c++) begin
				pixel[k][c*8 +: 8] = cfg.limited_range ? LIM_ROM[code_s2[k][c]]
				                                       : code_s2[k][c];
			end
			pixel[k][31:24] = cfg.alpha_enable ? alpha_s2[k] : 8'hFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			pixel_s3 <= pixel;
		end
	end

endmodule

`default_nettype wire

[rtl/yuv420_quad_to_bgra.sv]
// Converts one 2x2 quad of 4:2:0 BT.601-style YCbCr with four alphas into four
// packed BGRA pixels (blue 7:0, green 15:8, red 23:16, alpha 31:24). It accepts
// one quad per cycle while in_ready is high; each quad passes through registered
// stages: stage one looks up the chroma offsets in constant tables, stage two
// adds them to luma and clamps, stage three expands studio range through a
// 256-entry table and packs. A stalled output holds only the full stages between
// it and the first empty one; the others keep filling. Configuration writes are
// always ready and take effect at once, so change them only while the pipeline
// is empty. Depends on yuvq_pkg and the three stage modules.
`default_nettype none

module yuv420_quad_to_bgra import yuvq_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [7:0]             chroma_blue,
	input  wire logic [7:0]             chroma_red,
	input  wire logic [7:0]             luma_top_left,
	input  wire logic [7:0]             luma_bottom_left,
	input  wire logic [7:0]             luma_top_right,
	input  wire logic [7:0]             luma_bottom_right,
	input  wire logic [7:0]             alpha_top_left,
	input  wire logic [7:0]             alpha_bottom_left,
	input  wire logic [7:0]             alpha_top_right,
	input  wire logic [7:0]             alpha_bottom_right,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [31:0]                 pixel_top_left,
	output logic [31:0]                 pixel_bottom_left,
	output logic [31:0]                 pixel_top_right,
	output logic [31:0]                 pixel_bottom_right
);

	cfg_t        cfg_q;
	lane_byte_t  luma;
	lane_byte_t  alpha;
	logic        adv1;
	logic        adv2;
	logic        adv3;
	logic        valid_s1;
	logic        valid_s2;
	logic        valid_s3;
	chroma_off_t dr_s1;
	chroma_off_t dg_s1;
	chroma_off_t db_s1;
	lane_byte_t  luma_s1;
	lane_byte_t  alpha_s1;
	lane_code_t  code_s2;
	lane_byte_t  alpha_s2;
	lane_pixel_t pixel_s3;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LIMITED_RANGE: cfg_q.limited_range <= cfg_data[0];
				REG_ALPHA_ENABLE:  cfg_q.alpha_enable  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Lane order: top left, bottom left, top right, bottom right.
	assign luma  = {luma_bottom_right, luma_top_right, luma_bottom_left, luma_top_left};
	assign alpha = {alpha_bottom_right, alpha_top_right, alpha_bottom_left, alpha_top_left};

	// A stage may load when it is empty or its content moves on this cycle.
	assign adv3     = !valid_s3 || out_ready;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1;

	yuvq_offset u_offset (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.advance     (adv1),
		.chroma_blue (chroma_blue),
		.chroma_red  (chroma_red),
		.luma        (luma),
		.alpha       (alpha),
		.valid_s1    (valid_s1),
		.dr_s1       (dr_s1),
		.dg_s1       (dg_s1),
		.db_s1       (db_s1),
		.luma_s1     (luma_s1),
		.alpha_s1    (alpha_s1)
	);

	yuvq_range u_range (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.valid_s1 (valid_s1),
		.advance  (adv2),
		.dr_s1    (dr_s1),
		.dg_s1    (dg_s1),
		.db_s1    (db_s1),
		.luma_s1  (luma_s1),
		.alpha_s1 (alpha_s1),
		.valid_s2 (valid_s2),
		.code_s2  (code_s2),
		.alpha_s2 (alpha_s2)
	);

	yuvq_pack u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.valid_s2 (valid_s2),
		.advance  (adv3),
		.code_s2  (code_s2),
		.alpha_s2 (alpha_s2),
		.valid_s3 (valid_s3),
		.pixel_s3 (pixel_s3)
	);

	assign out_valid          = valid_s3;
	assign pixel_top_left     = pixel_s3[0];
	assign pixel_bottom_left  = pixel_s3[1];
	assign pixel_top_right    = pixel_s3[2];
	assign pixel_bottom_right = pixel_s3[3];

`ifndef SYNTH
	// Draining the output with nothing in stage two must leave it empty.
	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !valid_s2) |=> !out_valid)
		else $error("output stage refilled without a transaction behind it");

	// A stalled output must not drop the quad waiting in stage two.
	a_stall_holds_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && valid_s3 && !out_ready) |=> valid_s2)
		else $error("stage two lost a quad during an output stall");

	// A stalled stage one must keep its quad when stage two cannot take it.
	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv2) |=> (valid_s1 && $stable(dr_s1) && $stable(luma_s1)))
		else $error("stage one changed during a stall");

	// With alpha disabled every delivered pixel is opaque.
	a_alpha_forced: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !cfg_q.alpha_enable) |->
		(pixel_top_left[31:24] == 8'hFF && pixel_bottom_left[31:24] == 8'hFF &&
		 pixel_top_right[31:24] == 8'hFF && pixel_bottom_right[31:24] == 8'hFF))
		else $error("alpha not forced opaque");
`endif

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking bench for yuv420_quad_to_bgra: directed and random 2x2 quads go
// through an independent integer conversion and are compared pixel by pixel.
// Depends on yuvq_pkg and the converter RTL under rtl.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import yuvq_pkg::*;

	typedef struct packed {
		logic [7:0] cb;
		logic [7:0] cr;
		lane_byte_t luma;
		lane_byte_t alpha;
	} quad_t;

	localparam int PHASES           = 6;
	localparam int RANDOM_PER_PHASE = 238;
	localparam int PIPE_DRAIN       = 4;
	localparam int STUDIO_LO        = 16;
	localparam int STUDIO_HI        = 235;
	localparam int STUDIO_SPAN      = 219;

	// Settings per random phase, phase 0 in bit 0.
	localparam logic [PHASES-1:0] PHASE_LIMITED = 6'b010101;
	localparam logic [PHASES-1:0] PHASE_ALPHA   = 6'b010011;

	// Chroma pairs hold Cb in the high byte and Cr in the low byte.
	localparam logic [5:0][15:0] DIRECTED_CHROMA = {
		16'h017F, 16'h8080, 16'hFF00, 16'h00FF, 16'hFFFF, 16'h0000};
	localparam logic [1:0][31:0] DIRECTED_LUMA  = {32'h0180_EC0F, 32'hEB10_FF00};
	localparam logic [1:0][31:0] DIRECTED_ALPHA = {32'h8001_F00F, 32'hAA55_FF00};

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	quad_t                  quad_drv  = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [31:0]            pix_tl, pix_bl, pix_tr, pix_br;

	quad_t       quads_to_send[$];
	lane_pixel_t expected_pixels[$];
	logic        limited_cfg = 1'b0;
	logic        alpha_cfg   = 1'b0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          failures = 0;
	string       pixel_names [LANES] = '{"pixel_top_left", "pixel_bottom_left",
		"pixel_top_right", "pixel_bottom_right"};

	always #5 clk = ~clk;

	yuv420_quad_to_bgra i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.chroma_blue        (quad_drv.cb),
		.chroma_red         (quad_drv.cr),
		.luma_top_left      (quad_drv.luma[0]),
		.luma_bottom_left   (quad_drv.luma[1]),
		.luma_top_right     (quad_drv.luma[2]),
		.luma_bottom_right  (quad_drv.luma[3]),
		.alpha_top_left     (quad_drv.alpha[0]),
		.alpha_bottom_left  (quad_drv.alpha[1]),
		.alpha_top_right    (quad_drv.alpha[2]),
		.alpha_bottom_right (quad_drv.alpha[3]),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.pixel_top_left     (pix_tl),
		.pixel_bottom_left  (pix_bl),
		.pixel_top_right    (pix_tr),
		.pixel_bottom_right (pix_br)
	);

	function automatic logic [7:0] scale_channel(int y, int d, logic lim);
		int v;
		v = y + d;
		if (lim) begin
			if (v < STUDIO_LO)
				v = STUDIO_LO;
			else if (v > STUDIO_HI)
				v = STUDIO_HI;
			return 8'(((v - STUDIO_LO) * 255) / STUDIO_SPAN);
		end
		if (v < 0)
			v = 0;
		else if (v > 255)
			v = 255;
		return 8'(v);
	endfunction

	// SystemVerilog integer division truncates toward zero, which gives the
	// truncated chroma offsets directly.
	function automatic lane_pixel_t convert_quad(quad_t q, logic lim, logic alpha_en);
		lane_pixel_t px;
		int          cb, cr, dr, dg, db;
		logic [7:0]  a;
		cb = int'(q.cb) - 128;
		cr = int'(q.cr) - 128;
		dr = (419 * cr) / 299;
		dg = (-299 * cr) / 419 + (-114 * cb) / 331;
		db = (587 * cb) / 331;
		for (int k = 0; k < LANES; k++) begin
			a = alpha_en ? q.alpha[k] : 8'hFF;
			px[k] = {a, scale_channel(q.luma[k], dr, lim),
				scale_channel(q.luma[k], dg, lim), scale_channel(q.luma[k], db, lim)};
		end
		return px;
	endfunction

	// Bias toward the clamp regions and the chroma midpoint.
	function automatic logic [7:0] random_byte();
		case ($urandom_range(5))
			0: return 8'($urandom_range(20));
			1: return 8'($urandom_range(255, 215));
			2: return 8'($urandom_range(140, 116));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic quad_t random_quad();
		quad_t q;
		q.cb = random_byte();
		q.cr = random_byte();
		for (int k = 0; k < LANES; k++) begin
			q.luma[k] = random_byte();
			q.alpha[k] = 8'($urandom);
		end
		return q;
	endfunction

	task automatic queue_directed();
		quad_t q;
		for (int c = 0; c < 6; c++) begin
			for (int s = 0; s < 2; s++) begin
				q.cb = DIRECTED_CHROMA[c][15:8];
				q.cr = DIRECTED_CHROMA[c][7:0];
				q.luma = DIRECTED_LUMA[s];
				q.alpha = DIRECTED_ALPHA[s];
				quads_to_send.push_back(q);
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_LIMITED_RANGE: limited_cfg = data[0];
			REG_ALPHA_ENABLE: alpha_cfg = data[0];
			default: ;
		endcase
	endtask

	// Sampled on the falling edge so the queues have settled for the cycle.
	task automatic drain();
		while (quads_to_send.size() != 0 || in_valid || expected_pixels.size() != 0)
			@(negedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			quad_drv <= '0;
		end else begin
			if (in_valid && in_ready)
				expected_pixels.push_back(convert_quad(quad_drv, limited_cfg, alpha_cfg));
			if (!in_valid || in_ready) begin
				if (quads_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					quad_drv <= quads_to_send.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		lane_pixel_t got, want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= $urandom_range(99) >= recv_idle_pct;
			if (out_valid && out_ready) begin
				got = {pix_br, pix_tr, pix_bl, pix_tl};
				if (expected_pixels.size() == 0) begin
					$error("output transaction with nothing expected: %h", got);
					failures++;
				end else begin
					want = expected_pixels.pop_front();
					for (int k = 0; k < LANES; k++) begin
						if (got[k] !== want[k]) begin
							$error("%s: expected %h, actual %h", pixel_names[k], want[k], got[k]);
							failures++;
						end
					end
				end
			end
		end
	end

	initial begin
		logic [CFG_INDEX_W-1:0] stray_index;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 6;
		recv_idle_pct = 60;
		queue_directed();
		drain();
		for (int p = 0; p < PHASES; p++) begin
			if (p >= 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (p >= 2) begin
				send_idle_pct = 60;
				recv_idle_pct = 6;
			end
			// Upper data bits are random and must be ignored, as must a write
			// to an index past the last register.
			stray_index = CFG_INDEX_W'((2 ** CFG_INDEX_W) - 1 - p);
			write_reg(REG_LIMITED_RANGE, {7'($urandom), PHASE_LIMITED[p]});
			write_reg(stray_index, 8'($urandom));
			write_reg(REG_ALPHA_ENABLE, {7'($urandom), PHASE_ALPHA[p]});
			if (p == 0)
				queue_directed();
			repeat (RANDOM_PER_PHASE) quads_to_send.push_back(random_quad());
			drain();
		end
		if (failures == 0 && expected_pixels.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
